@@ src/dpc_pkg.sv @@
// shared types, widths and codes for the discordant pair counter
// no dependencies; every other file imports this package
package dpc_pkg;

	// position, counter and insert-size widths
	localparam int POS_W      = 31;
	localparam int CNT_W      = 32;
	localparam int OUT_W      = 32;
	localparam int MEAN_W     = 20;
	localparam int KIND_W     = 2;
	localparam int DIF_W      = POS_W + 1;
	localparam int UP_W       = MEAN_W + 2;
	localparam int LOW_W      = MEAN_W + 3;
	localparam int CMP_W      = ((POS_W > UP_W) ? POS_W : UP_W) + 3;
	localparam int CFG_DATA_W = (POS_W > MEAN_W) ? POS_W : MEAN_W;
	localparam int REG_IDX_W  = 3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_START = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_END   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KIND  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MEAN  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SD    = 3'd4;

	// event kinds; other codes count no pairs
	localparam logic [KIND_W-1:0] KIND_DEL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DUP = 2'd1;

	// one read beat
	typedef struct packed {
		logic             first_of_region;
		logic [POS_W-1:0] read_start;
		logic [POS_W-1:0] read_end;
		logic [POS_W-1:0] mate_start;
		logic             few_cigar_ops;
		logic             unmapped;
		logic             mate_elsewhere;
		logic             is_reverse;
		logic             mate_reverse;
		logic             mapq_zero;
	} item_t;

	// one result beat
	typedef struct packed {
		logic [OUT_W-1:0] overlap_reads;
		logic [OUT_W-1:0] zero_quality_reads;
		logic [OUT_W-1:0] supporting_pairs;
	} result_t;

	// ordered region and thresholds derived from the registers
	typedef struct packed {
		logic [POS_W-1:0]  lo;
		logic [POS_W-1:0]  hi;
		logic [POS_W:0]    len;
		logic [UP_W-1:0]   upper;
		logic [LOW_W-1:0]  lower;
		logic [KIND_W-1:0] kind;
	} cfg_t;

	// differences and read flags after the first stage
	typedef struct packed {
		logic             first;
		logic             count_ok;
		logic             hit;
		logic             q0;
		logic             pair_ok;
		logic [DIF_W-1:0] d;
		logic [DIF_W-1:0] e1;
		logic [DIF_W-1:0] e2;
		logic [DIF_W-1:0] span;
		logic [POS_W-1:0] mq;
		logic [POS_W-1:0] mp;
	} span_t;

	// counter increments after the decision stage
	typedef struct packed {
		logic first;
		logic inc_ovl;
		logic inc_q0;
		logic inc_sup;
	} flags_t;

	// extensions into the common compare width
	function automatic logic signed [CMP_W-1:0] sx_dif(logic [DIF_W-1:0] v);
		return $signed({{(CMP_W-DIF_W){v[DIF_W-1]}}, v});
	endfunction

	function automatic logic signed [CMP_W-1:0] zx_pos(logic [POS_W-1:0] v);
		return $signed({{(CMP_W-POS_W){1'b0}}, v});
	endfunction

	function automatic logic signed [CMP_W-1:0] zx_len(logic [POS_W:0] v);
		return $signed({{(CMP_W-POS_W-1){1'b0}}, v});
	endfunction

	function automatic logic signed [CMP_W-1:0] zx_up(logic [UP_W-1:0] v);
		return $signed({{(CMP_W-UP_W){1'b0}}, v});
	endfunction

	function automatic logic signed [CMP_W-1:0] sx_low(logic [LOW_W-1:0] v);
		return $signed({{(CMP_W-LOW_W){v[LOW_W-1]}}, v});
	endfunction

endpackage

@@ src/discordant_pair_counter.sv @@
// discordant_pair_counter: a read beat passes input, span, decide and count registers
// one read per cycle when not stalled; the counter update is a single increment stage
// a stalled result holds the pipeline, and item_stall rises only when all stages are full
// reset clears valid bits, counters and config registers; a write is seen via cfg_q
// depends on dpc_pkg, dpc_cfg, dpc_span, dpc_decide, dpc_count
module discordant_pair_counter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  dpc_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output dpc_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [dpc_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dpc_pkg::*;

	cfg_t   cfg;
	item_t  item_s1;
	span_t  span_s2;
	flags_t flags_s3;
	logic   v_s1;
	logic   v_s2;
	logic   v_s3;
	logic   out_free;
	logic   en1;
	logic   en2;
	logic   en3;

	// stage enables: a stage loads when empty or its successor moves
	assign en3        = !v_s3 || out_free;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign item_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= item_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en1 && item_valid) begin
			item_s1 <= item;
		end
	end

	dpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dpc_span u_span (
		.clk     (clk),
		.en      (en2),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.span_s2 (span_s2)
	);

	dpc_decide u_decide (
		.clk      (clk),
		.en       (en3),
		.span_s2  (span_s2),
		.cfg      (cfg),
		.flags_s3 (flags_s3)
	);

	dpc_count u_count (
		.clk          (clk),
		.arst_n       (arst_n),
		.flags_valid  (v_s3),
		.flags_s3     (flags_s3),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// back-pressure only with every stage full behind a stalled result
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (v_s1 && v_s2 && v_s3 && result_valid && result_stall))
		else $error("input stalled with room in the pipeline");

endmodule

@@ src/dpc_cfg.sv @@
// configuration registers and the derived region bounds and insert thresholds
// depends on dpc_pkg
module dpc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dpc_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data,
	output dpc_pkg::cfg_t                  cfg
);
	import dpc_pkg::*;

	logic [POS_W-1:0]  start_q;
	logic [POS_W-1:0]  end_q;
	logic [KIND_W-1:0] kind_q;
	logic [MEAN_W-1:0] mean_q;
	logic [MEAN_W-1:0] sd_q;
	cfg_t              cfg_q;
	cfg_t              cfg_c;
	logic              swap_c;
	logic [UP_W-1:0]   sd3_c;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
			kind_q  <= '0;
			mean_q  <= '0;
			sd_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START: start_q <= cfg_data[POS_W-1:0];
				REG_END:   end_q   <= cfg_data[POS_W-1:0];
				REG_KIND:  kind_q  <= cfg_data[KIND_W-1:0];
				REG_MEAN:  mean_q  <= cfg_data[MEAN_W-1:0];
				REG_SD:    sd_q    <= cfg_data[MEAN_W-1:0];
				default:   ;
			endcase
		end
	end

	// ordered bounds, region length and mean +/- 3 sd
	always_comb begin
		swap_c      = start_q > end_q;
		cfg_c.lo    = swap_c ? end_q : start_q;
		cfg_c.hi    = swap_c ? start_q : end_q;
		cfg_c.len   = swap_c ? ((POS_W+1)'(start_q) - (POS_W+1)'(end_q) + (POS_W+1)'(1))
		                     : ((POS_W+1)'(end_q) - (POS_W+1)'(start_q) + (POS_W+1)'(1));
		sd3_c       = UP_W'({sd_q, 1'b0}) + UP_W'(sd_q);
		cfg_c.upper = UP_W'(mean_q) + sd3_c;
		cfg_c.lower = LOW_W'(mean_q) - LOW_W'(sd3_c);
		cfg_c.kind  = kind_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else begin
			cfg_q <= cfg_c;
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/dpc_span.sv @@
// first stage: read flags, pair differences and clipped overlap ends
// depends on dpc_pkg
module dpc_span (
	input  logic           clk,
	input  logic           en,
	input  dpc_pkg::item_t item_s1,
	input  dpc_pkg::cfg_t  cfg,
	output dpc_pkg::span_t span_s2
);
	import dpc_pkg::*;

	span_t            span_c;
	logic             swap_c;
	logic [POS_W-1:0] p_c;
	logic [POS_W-1:0] q_c;

	always_comb begin
		// read-level classification
		span_c.first    = item_s1.first_of_region;
		span_c.count_ok = !item_s1.few_cigar_ops && !item_s1.unmapped;
		span_c.hit      = (item_s1.read_end > cfg.lo) && (item_s1.read_start < cfg.hi);
		span_c.q0       = item_s1.mapq_zero;
		span_c.pair_ok  = !item_s1.mate_elsewhere && (item_s1.is_reverse ^ item_s1.mate_reverse);

		// inner span from read end to mate start, and distances to the bounds
		span_c.d  = DIF_W'(item_s1.mate_start) - DIF_W'(item_s1.read_end);
		span_c.e1 = DIF_W'(item_s1.read_end) - DIF_W'(cfg.lo);
		span_c.e2 = DIF_W'(item_s1.mate_start) - DIF_W'(cfg.hi);

		// duplication orders the pair ends before the overlap test
		swap_c      = (cfg.kind == KIND_DUP) && (item_s1.read_end > item_s1.mate_start);
		p_c         = swap_c ? item_s1.mate_start : item_s1.read_end;
		q_c         = swap_c ? item_s1.read_end : item_s1.mate_start;
		span_c.span = swap_c ? (DIF_W'(0) - span_c.d) : span_c.d;
		span_c.mq   = (q_c < cfg.hi) ? q_c : cfg.hi;
		span_c.mp   = (p_c > cfg.lo) ? p_c : cfg.lo;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			span_s2 <= span_c;
		end
	end

endmodule

@@ src/dpc_decide.sv @@
// second stage: insert-size and half-overlap tests, counter increments
// depends on dpc_pkg
module dpc_decide (
	input  logic            clk,
	input  logic            en,
	input  dpc_pkg::span_t  span_s2,
	input  dpc_pkg::cfg_t   cfg,
	output dpc_pkg::flags_t flags_s3
);
	import dpc_pkg::*;

	flags_t                  flags_c;
	logic signed [CMP_W-1:0] d_c;
	logic signed [CMP_W-1:0] e1_c;
	logic signed [CMP_W-1:0] e2_c;
	logic signed [CMP_W-1:0] near_c;
	logic signed [CMP_W-1:0] ovl_c;
	logic signed [CMP_W-1:0] ovl2_c;
	logic signed [CMP_W-1:0] upper_c;
	logic                    is_near;
	logic                    is_wide;
	logic                    sup_c;

	always_comb begin
		d_c     = sx_dif(span_s2.d);
		e1_c    = sx_dif(span_s2.e1);
		e2_c    = sx_dif(span_s2.e2);
		upper_c = zx_up(cfg.upper);

		// summed distance of the pair ends to the bounds
		near_c  = (e1_c < 0 ? -e1_c : e1_c) + (e2_c < 0 ? -e2_c : e2_c);
		is_near = near_c < upper_c;

		// half-overlap against region length and pair span
		ovl_c   = zx_pos(span_s2.mq) - zx_pos(span_s2.mp);
		ovl2_c  = ovl_c <<< 1;
		is_wide = !(ovl2_c < zx_len(cfg.len)) && !(ovl2_c < sx_dif(span_s2.span));

		case (cfg.kind)
			KIND_DEL: sup_c = !(d_c < upper_c) && !(ovl_c < 0) && (is_near || is_wide);
			KIND_DUP: sup_c = !(d_c > sx_low(cfg.lower)) && (is_near || is_wide);
			default:  sup_c = 1'b0;
		endcase

		flags_c.first   = span_s2.first;
		flags_c.inc_ovl = span_s2.count_ok && span_s2.hit;
		flags_c.inc_q0  = span_s2.count_ok && span_s2.hit && span_s2.q0;
		flags_c.inc_sup = span_s2.count_ok && span_s2.pair_ok && sup_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s3 <= flags_c;
		end
	end

endmodule

@@ src/dpc_count.sv @@
// saturating counters that double as the result register
// depends on dpc_pkg
module dpc_count (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             flags_valid,
	input  dpc_pkg::flags_t  flags_s3,
	output logic             out_free,
	output logic             result_valid,
	input  logic             result_stall,
	output dpc_pkg::result_t result
);
	import dpc_pkg::*;

	logic             valid_q;
	logic [CNT_W-1:0] ovl_q;
	logic [CNT_W-1:0] zq_q;
	logic [CNT_W-1:0] sup_q;
	logic [CNT_W-1:0] ovl_base;
	logic [CNT_W-1:0] zq_base;
	logic [CNT_W-1:0] sup_base;
	logic             adv;

	// result slot is free when empty or being taken
	assign out_free = !valid_q || !result_stall;
	assign adv      = out_free && flags_valid;

	// region start clears the counts before this read
	always_comb begin
		ovl_base = flags_s3.first ? '0 : ovl_q;
		zq_base  = flags_s3.first ? '0 : zq_q;
		sup_base = flags_s3.first ? '0 : sup_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ovl_q   <= '0;
			zq_q    <= '0;
			sup_q   <= '0;
		end else begin
			if (out_free) begin
				valid_q <= flags_valid;
			end
			if (adv) begin
				ovl_q <= (flags_s3.inc_ovl && !(&ovl_base)) ? ovl_base + CNT_W'(1) : ovl_base;
				zq_q  <= (flags_s3.inc_q0 && !(&zq_base)) ? zq_base + CNT_W'(1) : zq_base;
				sup_q <= (flags_s3.inc_sup && !(&sup_base)) ? sup_base + CNT_W'(1) : sup_base;
			end
		end
	end

	assign result_valid              = valid_q;
	assign result.overlap_reads      = OUT_W'(ovl_q);
	assign result.zero_quality_reads = OUT_W'(zq_q);
	assign result.supporting_pairs   = OUT_W'(sup_q);

	// zero-quality reads are a subset of overlapping reads
	a_zq_le_ovl: assert property (@(posedge clk) disable iff (!arst_n)
		zq_q <= ovl_q)
		else $error("zero quality count above overlap count");

	// counts move only when a beat enters the result slot
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({ovl_q, zq_q, sup_q}))
		else $error("counters changed without a beat");

	// without a region start the support count never falls
	a_sup_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !flags_s3.first) |=> (sup_q >= $past(sup_q)))
		else $error("support count decreased");

endmodule
